[rtl/cba_pkg.sv]
// ----------------------------------------------------------------------------
// cba_pkg
// Shared types, widths and codes of the cluster bitmap allocator.
// ----------------------------------------------------------------------------
`default_nettype none

package cba_pkg;

  // default bitmap size
  localparam int unsigned MAX_CLUSTERS_DEF = 1024;

  // field widths
  localparam int unsigned CLUS_W  = 11;
  localparam int unsigned BASE_W  = 32;
  localparam int unsigned BPC_W   = 17;
  localparam int unsigned START_W = 10;
  localparam int unsigned ADDR_W  = 48;
  localparam int unsigned USED_W  = 11;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 32;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_CLUSTERS_IN_USE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DATA_BASE       = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BYTES_PER_CLUS  = 2'd2;

  // register reset values
  localparam logic [CLUS_W-1:0] CLUSTERS_RST = 11'd1024;
  localparam logic [BASE_W-1:0] BASE_RST     = 32'd0;
  localparam logic [BPC_W-1:0]  BPC_RST      = 17'd10;

  // request codes
  localparam logic OP_SINGLE = 1'b0;
  localparam logic OP_RUN    = 1'b1;

  typedef struct packed {
    logic              op;
    logic [CLUS_W-1:0] run_length;
  } req_t;

  typedef struct packed {
    logic               found;
    logic [START_W-1:0] start_cluster;
    logic [ADDR_W-1:0]  start_address;
    logic [USED_W-1:0]  used_count;
  } res_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SCAN,
    ST_MARK,
    ST_MULT
  } state_e;

endpackage

`default_nettype wire

[rtl/cba_ram.sv]
// ----------------------------------------------------------------------------
// cba_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module cba_ram #(
  parameter int unsigned WIDTH = 1,
  parameter int unsigned DEPTH = cba_pkg::MAX_CLUSTERS_DEF
) (
  input  wire                      clk_i,
  input  wire                      we_i,
  input  wire  [$clog2(DEPTH)-1:0] waddr_i,
  input  wire  [WIDTH-1:0]         wdata_i,
  input  wire  [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // write port and registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

[rtl/cba_addr_mul.sv]
// ----------------------------------------------------------------------------
// cba_addr_mul
// Bit-serial shift-add unit: base plus cluster index times cluster size,
// one index bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module cba_addr_mul #(
  parameter int unsigned IDX_W = 10
) (
  input  wire                                clk_i,
  input  wire                                rst_ni,
  input  wire                                go_i,
  input  wire  [IDX_W-1:0]                   idx_i,
  input  wire  [cba_pkg::BASE_W-1:0]         base_i,
  input  wire  [cba_pkg::BPC_W-1:0]          bpc_i,
  output logic                               done_o,
  output logic [cba_pkg::ADDR_W-1:0]         addr_o
);

  localparam int unsigned CNT_W = $clog2(IDX_W + 1);

  logic                       run_q, run_d;
  logic                       done_q, done_d;
  logic [CNT_W-1:0]           cnt_q, cnt_d;
  logic [IDX_W-1:0]           mplier_q, mplier_d;
  logic [cba_pkg::ADDR_W-1:0] mcand_q, mcand_d;
  logic [cba_pkg::ADDR_W-1:0] acc_q, acc_d;

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      run_q  <= run_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    mplier_q <= mplier_d;
    mcand_q  <= mcand_d;
    acc_q    <= acc_d;
  end

  // one multiplier bit per cycle
  always_comb begin
    run_d    = run_q;
    done_d   = 1'b0;
    cnt_d    = cnt_q;
    mplier_d = mplier_q;
    mcand_d  = mcand_q;
    acc_d    = acc_q;
    if (go_i) begin
      run_d    = 1'b1;
      cnt_d    = '0;
      mplier_d = idx_i;
      mcand_d  = cba_pkg::ADDR_W'(bpc_i);
      acc_d    = cba_pkg::ADDR_W'(base_i);
    end else if (run_q) begin
      if (mplier_q[0]) begin
        acc_d = acc_q + mcand_q;
      end
      mcand_d  = mcand_q << 1;
      mplier_d = mplier_q >> 1;
      cnt_d    = cnt_q + 1'b1;
      if (cnt_q == CNT_W'(IDX_W - 1)) begin
        run_d  = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  assign done_o = done_q;
  assign addr_o = acc_q;

endmodule

`default_nettype wire

[rtl/cluster_bitmap_allocator.sv]
// ----------------------------------------------------------------------------
// cluster_bitmap_allocator
// First-fit cluster allocator over a one-bit-per-cluster usage bitmap held in
// RAM, scanned one bit per cycle.
// ----------------------------------------------------------------------------
// Sequence: a zero-length run is answered from idle in the cycle after start;
//   a failed search ends once the search area is scanned; a hit scans at one
//   RAM read per cycle, then marks the run at one RAM write per cycle, then
//   runs the bit-serial address multiply. One item at a time (busy high
//   meanwhile, except for a zero-length run). Reset: a clearing pass zeroes
//   the bitmap with busy high; receiver cannot stall.
`default_nettype none

module cluster_bitmap_allocator #(
  parameter int unsigned MAX_CLUSTERS = cba_pkg::MAX_CLUSTERS_DEF
) (
  input  wire                               clk_i,
  input  wire                               rst_ni,
  input  wire                               start,
  output logic                              busy,
  input  wire  cba_pkg::req_t               req_i,
  output logic                              done_o,
  output cba_pkg::res_t                     result_o,
  input  wire                               cfg_valid_i,
  output logic                              cfg_ready_o,
  input  wire  [cba_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  wire  [cba_pkg::CFG_DATA_W-1:0]    cfg_data_i
);

  localparam int unsigned IW = $clog2(MAX_CLUSTERS);
  localparam int unsigned CW = $clog2(MAX_CLUSTERS + 1);
  localparam int unsigned LW = (CW > cba_pkg::CLUS_W) ? CW : cba_pkg::CLUS_W;
  localparam logic [LW-1:0] MAX_L = LW'(MAX_CLUSTERS);

  cba_pkg::state_e state_q, state_d;

  logic [IW-1:0]                  clr_idx_q, clr_idx_d;
  logic [LW-1:0]                  rd_idx_q, rd_idx_d;
  logic                           chk_vld_q, chk_vld_d;
  logic [IW-1:0]                  chk_idx_q, chk_idx_d;
  logic [LW-1:0]                  run_q, run_d;
  logic [IW-1:0]                  first_q, first_d;
  logic [LW-1:0]                  len_q, len_d;
  logic [IW-1:0]                  mark_idx_q, mark_idx_d;
  logic [LW-1:0]                  mark_left_q, mark_left_d;
  logic [IW-1:0]                  start_q, start_d;
  logic [cba_pkg::USED_W-1:0]     marked_q, marked_d;
  logic                           done_q, done_d;
  cba_pkg::res_t                  res_q, res_d;

  logic [cba_pkg::CLUS_W-1:0]     clusters_q;
  logic [cba_pkg::BASE_W-1:0]     base_q;
  logic [cba_pkg::BPC_W-1:0]      bpc_q;

  logic [LW-1:0]                  lim;
  logic                           issue;
  logic [LW-1:0]                  run_inc;
  logic [IW-1:0]                  hit_start;
  logic [LW-1:0]                  start_ext;

  logic                           ram_we;
  logic [IW-1:0]                  ram_waddr;
  logic                           ram_wdata;
  logic [IW-1:0]                  ram_raddr;
  logic                           ram_rdata;

  logic                           mul_go;
  logic                           mul_done;
  logic [cba_pkg::ADDR_W-1:0]     mul_addr;

  // usage bitmap storage
  cba_ram #(
    .WIDTH (1),
    .DEPTH (MAX_CLUSTERS)
  ) u_bitmap (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // start address: base + index * cluster size
  cba_addr_mul #(
    .IDX_W (IW)
  ) u_addr_mul (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .go_i   (mul_go),
    .idx_i  (start_q),
    .base_i (base_q),
    .bpc_i  (bpc_q),
    .done_o (mul_done),
    .addr_o (mul_addr)
  );

  // configuration registers
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clusters_q <= cba_pkg::CLUSTERS_RST;
      base_q     <= cba_pkg::BASE_RST;
      bpc_q      <= cba_pkg::BPC_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        cba_pkg::REG_CLUSTERS_IN_USE: clusters_q <= cfg_data_i[cba_pkg::CLUS_W-1:0];
        cba_pkg::REG_DATA_BASE:       base_q     <= cfg_data_i[cba_pkg::BASE_W-1:0];
        cba_pkg::REG_BYTES_PER_CLUS:  bpc_q      <= cfg_data_i[cba_pkg::BPC_W-1:0];
        default: ;
      endcase
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= cba_pkg::ST_CLEAR;
      clr_idx_q <= '0;
      chk_vld_q <= 1'b0;
      marked_q  <= '0;
      done_q    <= 1'b0;
    end else begin
      state_q   <= state_d;
      clr_idx_q <= clr_idx_d;
      chk_vld_q <= chk_vld_d;
      marked_q  <= marked_d;
      done_q    <= done_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    rd_idx_q    <= rd_idx_d;
    chk_idx_q   <= chk_idx_d;
    run_q       <= run_d;
    first_q     <= first_d;
    len_q       <= len_d;
    mark_idx_q  <= mark_idx_d;
    mark_left_q <= mark_left_d;
    start_q     <= start_d;
    res_q       <= res_d;
  end

  // search limit, saturated to the bitmap size
  assign lim       = (LW'(clusters_q) > MAX_L) ? MAX_L : LW'(clusters_q);
  assign issue     = (rd_idx_q < lim);
  assign run_inc   = run_q + 1'b1;
  assign hit_start = (run_q == '0) ? chk_idx_q : first_q;
  assign start_ext = LW'(start_q);

  // sequencer: clear, scan, mark, multiply
  always_comb begin
    state_d     = state_q;
    clr_idx_d   = clr_idx_q;
    rd_idx_d    = rd_idx_q;
    chk_vld_d   = chk_vld_q;
    chk_idx_d   = chk_idx_q;
    run_d       = run_q;
    first_d     = first_q;
    len_d       = len_q;
    mark_idx_d  = mark_idx_q;
    mark_left_d = mark_left_q;
    start_d     = start_q;
    marked_d    = marked_q;
    done_d      = 1'b0;
    res_d       = res_q;
    ram_we      = 1'b0;
    ram_waddr   = mark_idx_q;
    ram_wdata   = 1'b1;
    ram_raddr   = rd_idx_q[IW-1:0];
    mul_go      = 1'b0;

    unique case (state_q)
      cba_pkg::ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_idx_q;
        ram_wdata = 1'b0;
        clr_idx_d = clr_idx_q + 1'b1;
        if (clr_idx_q == IW'(MAX_CLUSTERS - 1)) begin
          state_d = cba_pkg::ST_IDLE;
        end
      end

      cba_pkg::ST_IDLE: begin
        if (start) begin
          if (req_i.op == cba_pkg::OP_RUN && req_i.run_length == '0) begin
            // zero-length run never succeeds
            res_d  = '{found: 1'b0, start_cluster: '0, start_address: '0,
                       used_count: marked_q};
            done_d = 1'b1;
          end else begin
            len_d     = (req_i.op == cba_pkg::OP_RUN) ? LW'(req_i.run_length) : LW'(1);
            rd_idx_d  = (req_i.op == cba_pkg::OP_RUN) ? LW'(0) : LW'(1);
            chk_vld_d = 1'b0;
            run_d     = '0;
            state_d   = cba_pkg::ST_SCAN;
          end
        end
      end

      cba_pkg::ST_SCAN: begin
        // issue next bitmap read
        if (issue) begin
          chk_vld_d = 1'b1;
          chk_idx_d = rd_idx_q[IW-1:0];
          rd_idx_d  = rd_idx_q + 1'b1;
        end else begin
          chk_vld_d = 1'b0;
        end
        // check the bit read last cycle
        if (chk_vld_q) begin
          if (!ram_rdata) begin
            run_d = run_inc;
            if (run_q == '0) begin
              first_d = chk_idx_q;
            end
            if (run_inc == len_q) begin
              start_d     = hit_start;
              mark_idx_d  = hit_start;
              mark_left_d = len_q;
              marked_d    = marked_q + len_q[cba_pkg::USED_W-1:0];
              chk_vld_d   = 1'b0;
              state_d     = cba_pkg::ST_MARK;
            end
          end else begin
            run_d = '0;
          end
        end else if (!issue) begin
          // search area exhausted
          res_d   = '{found: 1'b0, start_cluster: '0, start_address: '0,
                      used_count: marked_q};
          done_d  = 1'b1;
          state_d = cba_pkg::ST_IDLE;
        end
      end

      cba_pkg::ST_MARK: begin
        ram_we      = 1'b1;
        mark_idx_d  = mark_idx_q + 1'b1;
        mark_left_d = mark_left_q - 1'b1;
        if (mark_left_q == LW'(1)) begin
          mul_go  = 1'b1;
          state_d = cba_pkg::ST_MULT;
        end
      end

      cba_pkg::ST_MULT: begin
        if (mul_done) begin
          res_d   = '{found: 1'b1,
                      start_cluster: start_ext[cba_pkg::START_W-1:0],
                      start_address: mul_addr,
                      used_count: marked_q};
          done_d  = 1'b1;
          state_d = cba_pkg::ST_IDLE;
        end
      end

      default: begin
        state_d = cba_pkg::ST_IDLE;
      end
    endcase
  end

  assign busy     = (state_q != cba_pkg::ST_IDLE);
  assign done_o   = done_q;
  assign result_o = res_q;

endmodule

`default_nettype wire

[dv/testbench.sv]
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the cluster bitmap allocator. A directed table
// covers the corner cases: reset state, zero and oversized runs, search
// limits of zero, one and above the bitmap size, zero and maximum cluster
// size, register masking and an ignored index. Random phases with fresh
// register settings follow. Each result is compared with the value worked
// out in the table or with a behavioural model of the usage bitmap.
// ----------------------------------------------------------------------------
`default_nettype none

module testbench;

  // index past the end of the register list
  localparam logic [cba_pkg::CFG_IDX_W-1:0] REG_SPARE = 2'd3;
  localparam int unsigned MAXC = cba_pkg::MAX_CLUSTERS_DEF;

  // table entry of the directed part
  typedef struct {
    bit                            is_cfg;
    logic [cba_pkg::CFG_IDX_W-1:0]  idx;
    logic [cba_pkg::CFG_DATA_W-1:0] data;
    cba_pkg::req_t                 req;
    bit                            known;
    cba_pkg::res_t                 want;
  } step_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start = 1'b0;
  logic busy;
  cba_pkg::req_t req_i = '0;
  logic done_o;
  cba_pkg::res_t result_o;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [cba_pkg::CFG_IDX_W-1:0] cfg_index_i = '0;
  logic [cba_pkg::CFG_DATA_W-1:0] cfg_data_i = '0;

  // model of the allocator state and registers
  bit                         usage_map [MAXC];
  int unsigned                marked_total;
  logic [cba_pkg::CLUS_W-1:0] clusters_in_use;
  logic [cba_pkg::BASE_W-1:0] data_base;
  logic [cba_pkg::BPC_W-1:0]  bytes_per_clus;

  cba_pkg::res_t pending_allocs [$];
  int            mismatch_count = 0;
  step_t         plan [$];

  always #5 clk_i = ~clk_i;

  cluster_bitmap_allocator dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .req_i       (req_i),
    .done_o      (done_o),
    .result_o    (result_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("[%0t] mismatch on %s: got %0h, expected %0h", $realtime, what, got, want);
    mismatch_count++;
  endtask

  // first-fit search and marking, one item at a time
  function automatic cba_pkg::res_t allocate_clusters(input cba_pkg::req_t r);
    int unsigned lim, first, run, start_idx, span, i;
    bit ok;
    cba_pkg::res_t res;
    lim = (clusters_in_use > MAXC) ? MAXC : clusters_in_use;
    ok = 1'b0;
    start_idx = 0;
    span = 0;
    run = 0;
    first = 0;
    if (r.op == cba_pkg::OP_SINGLE) begin
      // index 0 is never handed out by a single request
      for (i = 1; i < lim; i++) begin
        if (!usage_map[i]) begin
          ok = 1'b1;
          start_idx = i;
          span = 1;
          break;
        end
      end
    end else if (r.run_length != 0) begin
      for (i = 0; i < lim; i++) begin
        if (!usage_map[i]) begin
          if (run == 0) first = i;
          run++;
          if (run == r.run_length) begin
            ok = 1'b1;
            start_idx = first;
            span = r.run_length;
            break;
          end
        end else begin
          run = 0;
        end
      end
    end
    if (ok) begin
      for (i = start_idx; i < start_idx + span; i++) usage_map[i] = 1'b1;
      marked_total += span;
    end
    res.found = ok;
    res.start_cluster = ok ? start_idx[cba_pkg::START_W-1:0] : '0;
    res.start_address = ok ? ({16'd0, data_base} +
                              48'(start_idx) * 48'(bytes_per_clus)) : '0;
    res.used_count = marked_total[cba_pkg::USED_W-1:0];
    return res;
  endfunction

  function automatic int unsigned pick_gap();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 60) return 0;
    if (roll < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 150);
  endfunction

  function automatic step_t cfg_row(input logic [cba_pkg::CFG_IDX_W-1:0] idx,
                                    input logic [cba_pkg::CFG_DATA_W-1:0] data);
    step_t s;
    s = '{default: '0};
    s.is_cfg = 1'b1;
    s.idx = idx;
    s.data = data;
    return s;
  endfunction

  function automatic step_t req_row(input logic op,
                                    input logic [cba_pkg::CLUS_W-1:0] len);
    step_t s;
    s = '{default: '0};
    s.req.op = op;
    s.req.run_length = len;
    return s;
  endfunction

  function automatic step_t req_known(input logic op,
                                      input logic [cba_pkg::CLUS_W-1:0] len,
                                      input logic found,
                                      input logic [cba_pkg::START_W-1:0] idx,
                                      input logic [cba_pkg::ADDR_W-1:0] addr,
                                      input logic [cba_pkg::USED_W-1:0] used);
    step_t s;
    s = req_row(op, len);
    s.known = 1'b1;
    s.want = '{found, idx, addr, used};
    return s;
  endfunction

  // register write, valid left high for a following write
  task automatic write_register(input logic [cba_pkg::CFG_IDX_W-1:0] idx,
                                input logic [cba_pkg::CFG_DATA_W-1:0] data,
                                input int unsigned gap);
    if (gap > 0) begin
      cfg_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    cfg_index_i <= idx;
    cfg_data_i <= data;
    cfg_valid_i <= 1'b1;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    case (idx)
      cba_pkg::REG_CLUSTERS_IN_USE: clusters_in_use = data[cba_pkg::CLUS_W-1:0];
      cba_pkg::REG_DATA_BASE:       data_base = data[cba_pkg::BASE_W-1:0];
      cba_pkg::REG_BYTES_PER_CLUS:  bytes_per_clus = data[cba_pkg::BPC_W-1:0];
      default: ;
    endcase
  endtask

  // issue one item, start left high for a following item
  task automatic issue_request(input cba_pkg::req_t r, input int unsigned gap,
                               input bit known, input cba_pkg::res_t want);
    cba_pkg::res_t pred;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    req_i <= r;
    start <= 1'b1;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    pred = allocate_clusters(r);
    pending_allocs.push_back(known ? want : pred);
  endtask

  // stop issuing and wait for every outstanding result
  task automatic quiesce(input int unsigned settle);
    start <= 1'b0;
    do @(posedge clk_i); while (pending_allocs.size() != 0);
    repeat (settle) @(posedge clk_i);
  endtask

  // result checking
  always @(posedge clk_i) begin : check_results
    cba_pkg::res_t want;
    if (rst_ni && done_o) begin
      if (pending_allocs.size() == 0) begin
        report_mismatch("unexpected result", 64'(result_o), 64'd0);
      end else begin
        want = pending_allocs.pop_front();
        if (result_o.found !== want.found)
          report_mismatch("found", 64'(result_o.found), 64'(want.found));
        if (result_o.start_cluster !== want.start_cluster)
          report_mismatch("start_cluster", 64'(result_o.start_cluster),
                          64'(want.start_cluster));
        if (result_o.start_address !== want.start_address)
          report_mismatch("start_address", 64'(result_o.start_address),
                          64'(want.start_address));
        if (result_o.used_count !== want.used_count)
          report_mismatch("used_count", 64'(result_o.used_count), 64'(want.used_count));
      end
    end
  end

  // watchdog
  initial begin
    #60_000_000;
    $display("** cluster_bitmap_allocator: FAILED **");
    $finish;
  end

  // stimulus
  initial begin : stimulus
    bit          prev_req;
    bit          quiet;
    int unsigned p, k, roll, rot, lim;
    logic [cba_pkg::CFG_DATA_W-1:0] value;
    cba_pkg::req_t r;

    foreach (usage_map[i]) usage_map[i] = 1'b0;
    marked_total = 0;
    clusters_in_use = cba_pkg::CLUSTERS_RST;
    data_base = cba_pkg::BASE_RST;
    bytes_per_clus = cba_pkg::BPC_RST;

    // directed corner cases
    plan.push_back(req_known(cba_pkg::OP_SINGLE, 11'd0, 1'b1, 10'd1, 48'd10, 11'd1));
    plan.push_back(req_known(cba_pkg::OP_RUN, 11'd0, 1'b0, 10'd0, 48'd0, 11'd1));
    plan.push_back(req_known(cba_pkg::OP_RUN, 11'h7FF, 1'b0, 10'd0, 48'd0, 11'd1));
    plan.push_back(req_known(cba_pkg::OP_RUN, 11'd1, 1'b1, 10'd0, 48'd0, 11'd2));
    plan.push_back(req_known(cba_pkg::OP_RUN, 11'd3, 1'b1, 10'd2, 48'd20, 11'd5));
    plan.push_back(cfg_row(cba_pkg::REG_DATA_BASE, 32'hFFFF_FFFF));
    plan.push_back(cfg_row(cba_pkg::REG_BYTES_PER_CLUS, 32'h0001_0000));
    plan.push_back(req_row(cba_pkg::OP_SINGLE, 11'h7FF));
    plan.push_back(req_row(cba_pkg::OP_RUN, 11'd4));
    plan.push_back(cfg_row(cba_pkg::REG_BYTES_PER_CLUS, 32'hFFFE_0000));
    plan.push_back(req_row(cba_pkg::OP_SINGLE, 11'd5));
    plan.push_back(cfg_row(cba_pkg::REG_CLUSTERS_IN_USE, 32'd0));
    plan.push_back(req_known(cba_pkg::OP_SINGLE, 11'd0, 1'b0, 10'd0, 48'd0, 11'd11));
    plan.push_back(req_known(cba_pkg::OP_RUN, 11'd1, 1'b0, 10'd0, 48'd0, 11'd11));
    plan.push_back(cfg_row(cba_pkg::REG_CLUSTERS_IN_USE, 32'd1));
    plan.push_back(req_known(cba_pkg::OP_SINGLE, 11'd0, 1'b0, 10'd0, 48'd0, 11'd11));
    plan.push_back(req_known(cba_pkg::OP_RUN, 11'd1, 1'b0, 10'd0, 48'd0, 11'd11));
    plan.push_back(cfg_row(cba_pkg::REG_CLUSTERS_IN_USE, 32'hFFFF_FFFF));
    plan.push_back(req_known(cba_pkg::OP_RUN, 11'd1024, 1'b0, 10'd0, 48'd0, 11'd11));
    plan.push_back(cfg_row(cba_pkg::REG_BYTES_PER_CLUS, 32'h0001_FFFF));
    plan.push_back(req_row(cba_pkg::OP_RUN, 11'd5));
    plan.push_back(cfg_row(cba_pkg::REG_CLUSTERS_IN_USE, 32'd8));
    plan.push_back(req_known(cba_pkg::OP_SINGLE, 11'd0, 1'b0, 10'd0, 48'd0, 11'd16));
    plan.push_back(cfg_row(REG_SPARE, 32'h0000_0005));
    plan.push_back(req_known(cba_pkg::OP_RUN, 11'd1024, 1'b0, 10'd0, 48'd0, 11'd16));

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    prev_req = 1'b1;
    foreach (plan[n]) begin
      if (plan[n].is_cfg) begin
        if (prev_req) quiesce(2);
        write_register(plan[n].idx, plan[n].data, pick_gap());
        prev_req = 1'b0;
      end else begin
        if (!prev_req) cfg_valid_i <= 1'b0;
        issue_request(plan[n].req, pick_gap(), plan[n].known, plan[n].want);
        prev_req = 1'b1;
      end
    end

    // random phases, search area widened phase by phase
    for (p = 0; p < 11; p++) begin
      quiesce(2);
      rot = $urandom_range(0, 2);
      for (k = 0; k < 3; k++) begin
        case ((k + rot) % 3)
          0: begin
            lim = 40 + 95 * p;
            if (p == 10) lim = MAXC;
            roll = $urandom_range(0, 7);
            if (roll == 0) lim = $urandom_range(0, 1);
            else if (roll == 1) lim = $urandom_range(MAXC, 2047);
            value = lim;
            // garbage above the register width must be dropped
            if ($urandom_range(0, 3) == 0)
              value[cba_pkg::CFG_DATA_W-1:cba_pkg::CLUS_W] =
                (cba_pkg::CFG_DATA_W - cba_pkg::CLUS_W)'($urandom);
            write_register(cba_pkg::REG_CLUSTERS_IN_USE, value, pick_gap());
          end
          1: begin
            roll = $urandom_range(0, 4);
            value = (roll == 0) ? 32'd0 : (roll == 1) ? 32'hFFFF_FFFF : $urandom;
            write_register(cba_pkg::REG_DATA_BASE, value, pick_gap());
          end
          default: begin
            roll = $urandom_range(0, 5);
            case (roll)
              0: value = 32'd0;
              1: value = 32'd1;
              2: value = 32'h0001_0000;
              3: value = $urandom;
              default: value = $urandom_range(1, 4096);
            endcase
            write_register(cba_pkg::REG_BYTES_PER_CLUS, value, pick_gap());
          end
        endcase
      end
      if ($urandom_range(0, 4) == 0) write_register(REG_SPARE, $urandom, pick_gap());
      cfg_valid_i <= 1'b0;

      quiet = ($urandom_range(0, 3) == 0);
      for (k = 0; k < 53; k++) begin
        r.op = 1'($urandom_range(0, 1));
        roll = $urandom_range(0, 99);
        if (roll < 8) r.run_length = '0;
        else if (roll < 14) r.run_length = cba_pkg::CLUS_W'($urandom_range(0, 2047));
        else if (roll < 80) r.run_length = cba_pkg::CLUS_W'($urandom_range(1, 8));
        else r.run_length = cba_pkg::CLUS_W'($urandom_range(1, 64));
        // now and then let the block drain completely
        if ($urandom_range(0, 24) == 0) quiesce(0);
        issue_request(r, quiet ? 0 : pick_gap(), 1'b0, '0);
      end
    end

    quiesce(20);
    if (mismatch_count == 0) begin
      $display("** cluster_bitmap_allocator: PASSED **");
    end else begin
      $display("** cluster_bitmap_allocator: FAILED **");
    end
    $finish;
  end

endmodule

`default_nettype wire
